>>> rtl/rdct_pkg.sv
// Package with the shared types and codes of the reload down-counter timer.
`default_nettype none

package rdct_pkg;

  localparam int DATA_W      = 24;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 32;

  // Result word layout.
  localparam int OUT_IRQ_BIT = 24;
  localparam int OUT_CNT_BIT = 25;

  // Control register layout.
  localparam int CTRL_EN_BIT   = 0;
  localparam int CTRL_IRQ_BIT  = 1;
  localparam int CTRL_SRC_BIT  = 2;
  localparam int CTRL_ONE_BIT  = 3;
  localparam int CTRL_FLAG_BIT = 16;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] REG_CTRL    = 2'd0;
  localparam logic [1:0] REG_RELOAD  = 2'd1;
  localparam logic [1:0] REG_CURRENT = 2'd2;
  localparam logic [1:0] REG_ELAPSED = 2'd3;

  typedef struct packed {
    logic              clock_is_core;
    logic [1:0]        reg_addr;
    logic [1:0]        req_type;
    logic [DATA_W-1:0] write_data;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/reload_down_counter_timer.sv
// Top level of the reload down-counter timer: input stage, register file and result stage.
//
// One stream channel carries requests in: clock ticks, register writes and
// register reads. Each request gives exactly one result transaction on the
// output channel with the read value, an interrupt pulse and the enable bit.
// A tick counts only when the timer is enabled and its clock kind matches
// the selected source; a counting tick at zero reloads, and the step from
// one to zero sets the count flag and pulses the interrupt if enabled.
// A request accepted into the input register is executed from there, and its
// result is registered in the result register. Throughput: one request per
// cycle while the receiver keeps out_tready high.
// The input register and the result register advance together; when the
// receiver holds out_tready low, the result holds and the input register
// still takes one more request before in_tready drops.
// Reset clears all timer registers, the count and both valid flags.
`default_nettype none

module reload_down_counter_timer #(
  parameter int COUNTER_WIDTH = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // write_data [23:0]
  input  wire logic [rdct_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type [1:0], reg_addr [3:2], clock_is_core [4]
  input  wire logic [rdct_pkg::IN_TUSER_W-1:0]   in_tuser,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // read_data [23:0], irq_pulse [24], counting [25], zero fill [31:26]
  output      logic [rdct_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import rdct_pkg::*;

  localparam int CW = COUNTER_WIDTH;

  logic          s1_valid_r;
  item_t         s1_item_r;
  logic          adv;
  logic          exec;

  logic          en_r, en_nxt;
  logic          irq_en_r, irq_en_nxt;
  logic          src_r, src_nxt;
  logic          one_r, one_nxt;
  logic          flag_r, flag_nxt;
  logic [CW-1:0] reload_r, reload_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] elapsed;
  logic [31:0]   wide_rd;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_irq_r, out_irq_nxt;
  logic              out_cnt_r;

  // The whole pipe moves when the result register is free or being taken.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign exec      = s1_valid_r && adv;
  assign elapsed   = reload_r - cnt_r;

  always_comb begin
    en_nxt       = en_r;
    irq_en_nxt   = irq_en_r;
    src_nxt      = src_r;
    one_nxt      = one_r;
    flag_nxt     = flag_r;
    reload_nxt   = reload_r;
    cnt_nxt      = cnt_r;
    out_irq_nxt  = 1'b0;
    wide_rd      = '0;
    out_data_nxt = '0;
    if (exec) begin
      unique case (s1_item_r.req_type)
        REQ_TICK: begin
          if (en_r && (src_r == s1_item_r.clock_is_core)) begin
            if (cnt_r == '0) begin
              cnt_nxt = reload_r;
            end else begin
              cnt_nxt = cnt_r - CW'(1);
              if (cnt_r == CW'(1)) begin
                flag_nxt    = 1'b1;
                out_irq_nxt = irq_en_r;
                if (one_r) begin
                  en_nxt     = 1'b0;
                  irq_en_nxt = 1'b0;
                end
              end
            end
          end
        end
        REQ_WRITE: begin
          unique case (s1_item_r.reg_addr)
            REG_CTRL: begin
              en_nxt     = s1_item_r.write_data[CTRL_EN_BIT];
              irq_en_nxt = s1_item_r.write_data[CTRL_IRQ_BIT];
              src_nxt    = s1_item_r.write_data[CTRL_SRC_BIT];
              one_nxt    = s1_item_r.write_data[CTRL_ONE_BIT];
            end
            REG_RELOAD: begin
              reload_nxt = CW'(s1_item_r.write_data);
            end
            REG_CURRENT: begin
              cnt_nxt  = '0;
              flag_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
        REQ_READ: begin
          unique case (s1_item_r.reg_addr)
            REG_CTRL: begin
              wide_rd[CTRL_EN_BIT]   = en_r;
              wide_rd[CTRL_IRQ_BIT]  = irq_en_r;
              wide_rd[CTRL_SRC_BIT]  = src_r;
              wide_rd[CTRL_ONE_BIT]  = one_r;
              wide_rd[CTRL_FLAG_BIT] = flag_r;
              flag_nxt               = 1'b0;
            end
            REG_RELOAD:  wide_rd = 32'(reload_r);
            REG_CURRENT: wide_rd = 32'(cnt_r);
            default:     wide_rd = 32'(elapsed);
          endcase
          out_data_nxt = wide_rd[DATA_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      en_r        <= 1'b0;
      irq_en_r    <= 1'b0;
      src_r       <= 1'b0;
      one_r       <= 1'b0;
      flag_r      <= 1'b0;
      reload_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      en_r     <= en_nxt;
      irq_en_r <= irq_en_nxt;
      src_r    <= src_nxt;
      one_r    <= one_nxt;
      flag_r   <= flag_nxt;
      reload_r <= reload_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.write_data    <= in_tdata[DATA_W-1:0];
      s1_item_r.req_type      <= in_tuser[1:0];
      s1_item_r.reg_addr      <= in_tuser[3:2];
      s1_item_r.clock_is_core <= in_tuser[4];
    end
    if (exec) begin
      out_data_r <= out_data_nxt;
      out_irq_r  <= out_irq_nxt;
      out_cnt_r  <= en_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - DATA_W - 2){1'b0}}, out_cnt_r, out_irq_r, out_data_r};

endmodule

`default_nettype wire

>>> rtl/rdct_checker.sv
// Port-level checker for the reload down-counter timer and its bind statement.
`default_nettype none

module rdct_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [rdct_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import rdct_pkg::*;

  // No result may be offered in the cycle after a reset cycle.
  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // An interrupt pulse only comes from a tick, which reads back zero.
  a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_IRQ_BIT] |-> out_tdata[DATA_W-1:0] == '0)
    else $error("interrupt pulse with read data");

  // The pad bits of the result word are always zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:OUT_CNT_BIT+1] == '0)
    else $error("result pad bits set");

  // With the result side free, the input side never stalls.
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result stage");

endmodule

bind reload_down_counter_timer rdct_checker u_rdct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
